// ===== sv/rhht_pkg.sv =====
// Shared types and constants for the Robin Hood hash table.
// No dependencies; used by the interfaces, controller, datapath and top level.
package rhht_pkg;

  localparam int unsigned KEY_W   = 64;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned LIMIT_W = 6;
  localparam int unsigned HASH_W  = 32;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 6'd24;
  localparam logic [HASH_W-1:0]  FNV_BASIS   = 32'd2166136261;
  localparam logic [HASH_W-1:0]  FNV_PRIME   = 32'd16777619;

  localparam logic [1:0] ACT_GET    = 2'd0;
  localparam logic [1:0] ACT_PUT    = 2'd1;
  localparam logic [1:0] ACT_REMOVE = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_LIMIT    = 2'd2;
  localparam logic [1:0] ST_NOROOM   = 2'd3;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_LOAD,
    OP_HASH,
    OP_MOD,
    OP_FIND_INIT,
    OP_FIND_CHK,
    OP_GET_HIT,
    OP_UPDATE,
    OP_INS_INIT,
    OP_INS_CHK,
    OP_REM_INIT,
    OP_REM_CHK,
    OP_REM_CLR,
    OP_EMIT
  } dp_op_e;

  typedef struct packed {
    dp_op_e     op;
    logic       set_status;
    logic [1:0] status;
  } dp_cmd_t;

  typedef struct packed {
    logic       clr_last;
    logic       hash_last;
    logic       mod_last;
    logic       find_end;
    logic       found;
    logic [1:0] act;
    logic       over_limit;
    logic       full;
    logic       ins_end;
    logic       rem_stop;
    logic       rem_last;
    logic       out_busy;
  } dp_sts_t;

endpackage

// ===== sv/rhht_req_if.sv =====
// Request channel: valid/ready handshake carrying action, key and value.
// Depends on rhht_pkg for field widths.
interface rhht_req_if;
  logic                               valid;
  logic                               ready;
  logic [1:0]                         action;
  logic [rhht_pkg::KEY_W-1:0]         key;
  logic signed [rhht_pkg::VALUE_W-1:0] value;

  modport source (output valid, action, key, value, input ready);
  modport sink   (input valid, action, key, value, output ready);
endinterface

// ===== sv/rhht_rsp_if.sv =====
// Response channel: valid/ready handshake carrying status, value and count.
// Depends on rhht_pkg; count width follows the table capacity.
interface rhht_rsp_if #(
  parameter int unsigned CNT_W = 6
);
  logic                                valid;
  logic                                ready;
  logic [1:0]                          status;
  logic signed [rhht_pkg::VALUE_W-1:0] found_value;
  logic [CNT_W-1:0]                    entry_count;

  modport source (output valid, status, found_value, entry_count, input ready);
  modport sink   (input valid, status, found_value, entry_count, output ready);
endinterface

// ===== sv/rhht_cfg_if.sv =====
// Configuration write channel: valid/ready handshake carrying load_limit.
// Depends on rhht_pkg for the register width.
interface rhht_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [rhht_pkg::LIMIT_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== sv/rhht_ctrl.sv =====
// Sequencing state machine for the hash table; issues datapath commands.
// Depends on rhht_pkg for the command and status structs.
module rhht_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  input  rhht_pkg::dp_sts_t sts_i,
  output rhht_pkg::dp_cmd_t cmd_o
);

  localparam logic [3:0] S_CLEAR     = 4'd0;
  localparam logic [3:0] S_IDLE      = 4'd1;
  localparam logic [3:0] S_HASH      = 4'd2;
  localparam logic [3:0] S_MOD       = 4'd3;
  localparam logic [3:0] S_FIND_INIT = 4'd4;
  localparam logic [3:0] S_FIND_WAIT = 4'd5;
  localparam logic [3:0] S_FIND_CHK  = 4'd6;
  localparam logic [3:0] S_DISPATCH  = 4'd7;
  localparam logic [3:0] S_INS_WAIT  = 4'd8;
  localparam logic [3:0] S_INS_CHK   = 4'd9;
  localparam logic [3:0] S_REM_WAIT  = 4'd10;
  localparam logic [3:0] S_REM_CHK   = 4'd11;
  localparam logic [3:0] S_REM_CLR   = 4'd12;
  localparam logic [3:0] S_EMIT      = 4'd13;

  logic [3:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d           = state_q;
    cmd_o.op          = rhht_pkg::OP_NONE;
    cmd_o.set_status  = 1'b0;
    cmd_o.status      = rhht_pkg::ST_OK;
    req_ready_o       = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.op = rhht_pkg::OP_CLEAR;
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.op = rhht_pkg::OP_LOAD;
          state_d  = S_HASH;
        end
      end
      S_HASH: begin
        cmd_o.op = rhht_pkg::OP_HASH;
        if (sts_i.hash_last) state_d = S_MOD;
      end
      S_MOD: begin
        cmd_o.op = rhht_pkg::OP_MOD;
        if (sts_i.mod_last) state_d = S_FIND_INIT;
      end
      S_FIND_INIT: begin
        cmd_o.op = rhht_pkg::OP_FIND_INIT;
        state_d  = S_FIND_WAIT;
      end
      S_FIND_WAIT: state_d = S_FIND_CHK;
      S_FIND_CHK: begin
        cmd_o.op = rhht_pkg::OP_FIND_CHK;
        state_d  = sts_i.find_end ? S_DISPATCH : S_FIND_WAIT;
      end
      S_DISPATCH: begin
        state_d = S_EMIT;
        unique case (sts_i.act)
          rhht_pkg::ACT_GET: begin
            if (sts_i.found) cmd_o.op = rhht_pkg::OP_GET_HIT;
          end
          rhht_pkg::ACT_PUT: begin
            if (sts_i.over_limit) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = rhht_pkg::ST_LIMIT;
            end else if (sts_i.found) begin
              cmd_o.op = rhht_pkg::OP_UPDATE;
            end else if (sts_i.full) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = rhht_pkg::ST_NOROOM;
            end else begin
              cmd_o.op = rhht_pkg::OP_INS_INIT;
              state_d  = S_INS_WAIT;
            end
          end
          rhht_pkg::ACT_REMOVE: begin
            if (sts_i.found) begin
              cmd_o.op = rhht_pkg::OP_REM_INIT;
              state_d  = S_REM_WAIT;
            end
          end
          default: state_d = S_EMIT;
        endcase
      end
      S_INS_WAIT: state_d = S_INS_CHK;
      S_INS_CHK: begin
        cmd_o.op = rhht_pkg::OP_INS_CHK;
        state_d  = sts_i.ins_end ? S_EMIT : S_INS_WAIT;
      end
      S_REM_WAIT: state_d = S_REM_CHK;
      S_REM_CHK: begin
        if (sts_i.rem_stop) begin
          state_d = S_EMIT;
        end else begin
          cmd_o.op = rhht_pkg::OP_REM_CHK;
          state_d  = S_REM_CLR;
        end
      end
      S_REM_CLR: begin
        cmd_o.op = rhht_pkg::OP_REM_CLR;
        state_d  = sts_i.rem_last ? S_EMIT : S_REM_WAIT;
      end
      S_EMIT: begin
        if (!sts_i.out_busy) begin
          cmd_o.op = rhht_pkg::OP_EMIT;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase
  end

endmodule

// ===== sv/rhht_dp.sv =====
// Datapath: FNV-1a hash, modulo unit, slot memory, probe and shift registers.
// Depends on rhht_pkg; driven by commands from rhht_ctrl.
module rhht_dp #(
  parameter int unsigned CAPACITY  = 32,
  parameter int unsigned KEY_BYTES = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  rhht_pkg::dp_cmd_t                   cmd_i,
  output rhht_pkg::dp_sts_t                   sts_o,
  input  logic [1:0]                          req_action_i,
  input  logic [rhht_pkg::KEY_W-1:0]          req_key_i,
  input  logic signed [rhht_pkg::VALUE_W-1:0] req_value_i,
  input  logic                                cfg_valid_i,
  input  logic [rhht_pkg::LIMIT_W-1:0]        cfg_data_i,
  input  logic                                rsp_ready_i,
  output logic                                rsp_valid_o,
  output logic [1:0]                          rsp_status_o,
  output logic signed [rhht_pkg::VALUE_W-1:0] rsp_found_value_o,
  output logic [$clog2(CAPACITY+1)-1:0]       rsp_entry_count_o
);

  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned LW = (CW > rhht_pkg::LIMIT_W) ? CW : rhht_pkg::LIMIT_W;
  localparam int unsigned KW = rhht_pkg::KEY_W;
  localparam int unsigned VW = rhht_pkg::VALUE_W;
  localparam int unsigned HW = rhht_pkg::HASH_W;
  localparam logic [IW-1:0] LAST_IDX = IW'(CAPACITY - 1);
  // Reciprocal of CAPACITY scaled by 2^SH, rounded up; exact for any 32-bit hash
  localparam int unsigned SH = HW + IW;
  localparam int unsigned PW = HW + 34;
  localparam logic [63:0] RECIP = ((64'd1 << SH) + 64'(CAPACITY) - 64'd1) / 64'(CAPACITY);

  // Slot memory
  logic          mem_v   [CAPACITY];
  logic [KW-1:0] mem_k   [CAPACITY];
  logic [VW-1:0] mem_val [CAPACITY];
  logic [IW-1:0] mem_d   [CAPACITY];

  logic          we;
  logic [IW-1:0] wa;
  logic          wv;
  logic [KW-1:0] wk;
  logic [VW-1:0] wval;
  logic [IW-1:0] wd;

  logic          rd_v_q;
  logic [KW-1:0] rd_k_q;
  logic [VW-1:0] rd_val_q;
  logic [IW-1:0] rd_d_q;

  // Work registers
  logic [IW-1:0]              clr_q, clr_d;
  logic [1:0]                 act_q, act_d;
  logic [KW-1:0]              key_q, key_d;
  logic [VW-1:0]              val_q, val_d;
  logic [rhht_pkg::HASH_W-1:0] hash_q, hash_d;
  logic [2:0]                 byte_n_q, byte_n_d;
  logic [4:0]                 bit_n_q, bit_n_d;
  logic [HW-1:0]              quo_q, quo_d;
  logic [IW-1:0]              rem_q, rem_d;
  logic [IW-1:0]              idx_q, idx_d;
  logic [IW-1:0]              prev_q, prev_d;
  logic [IW-1:0]              i_q, i_d;
  logic                       found_q, found_d;
  logic [IW-1:0]              pos_q, pos_d;
  logic [VW-1:0]              pos_val_q, pos_val_d;
  logic [IW-1:0]              pos_dist_q, pos_dist_d;
  logic [KW-1:0]              ck_q, ck_d;
  logic [VW-1:0]              cv_q, cv_d;
  logic [IW:0]                cd_q, cd_d;
  logic [1:0]                 res_status_q, res_status_d;
  logic [VW-1:0]              res_fval_q, res_fval_d;
  logic [CW-1:0]              count_q, count_d;
  logic [rhht_pkg::LIMIT_W-1:0] limit_q, limit_d;
  logic                       rsp_valid_q, rsp_valid_d;
  logic [1:0]                 rsp_status_q, rsp_status_d;
  logic [VW-1:0]              rsp_fval_q, rsp_fval_d;
  logic [CW-1:0]              rsp_count_q, rsp_count_d;

  logic [7:0]                 hbyte;
  logic [63:0]                prod;
  logic [PW-1:0]              mulp;
  logic                       f_miss;
  logic                       f_hit;

  function automatic logic [IW-1:0] nxt(input logic [IW-1:0] a);
    return (a == LAST_IDX) ? '0 : a + IW'(1);
  endfunction

  // Keep bytes up to the first zero byte and below KEY_BYTES
  function automatic logic [KW-1:0] norm_key(input logic [KW-1:0] k);
    logic [KW-1:0] r;
    logic          live;
    r    = '0;
    live = 1'b1;
    for (int b = 0; b < 8; b++) begin
      if (b >= KEY_BYTES || k[8*b +: 8] == 8'd0) live = 1'b0;
      if (live) r[8*b +: 8] = k[8*b +: 8];
    end
    return r;
  endfunction

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_v[wa]   <= wv;
      mem_k[wa]   <= wk;
      mem_val[wa] <= wval;
      mem_d[wa]   <= wd;
    end
    rd_v_q   <= mem_v[idx_q];
    rd_k_q   <= mem_k[idx_q];
    rd_val_q <= mem_val[idx_q];
    rd_d_q   <= mem_d[idx_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      count_q     <= '0;
      limit_q     <= rhht_pkg::LIMIT_RESET;
      rsp_valid_q <= 1'b0;
    end else begin
      clr_q       <= clr_d;
      count_q     <= count_d;
      limit_q     <= limit_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q        <= act_d;
    key_q        <= key_d;
    val_q        <= val_d;
    hash_q       <= hash_d;
    byte_n_q     <= byte_n_d;
    bit_n_q      <= bit_n_d;
    quo_q        <= quo_d;
    rem_q        <= rem_d;
    idx_q        <= idx_d;
    prev_q       <= prev_d;
    i_q          <= i_d;
    found_q      <= found_d;
    pos_q        <= pos_d;
    pos_val_q    <= pos_val_d;
    pos_dist_q   <= pos_dist_d;
    ck_q         <= ck_d;
    cv_q         <= cv_d;
    cd_q         <= cd_d;
    res_status_q <= res_status_d;
    res_fval_q   <= res_fval_d;
    rsp_status_q <= rsp_status_d;
    rsp_fval_q   <= rsp_fval_d;
    rsp_count_q  <= rsp_count_d;
  end

  assign hbyte  = key_q[8*byte_n_q +: 8];
  assign prod   = 64'(hash_q ^ {24'd0, hbyte}) * 64'(rhht_pkg::FNV_PRIME);
  assign mulp   = PW'(hash_q) * PW'(RECIP);
  assign f_miss = !rd_v_q || (rd_d_q < i_q);
  assign f_hit  = !f_miss && (rd_k_q == key_q);

  always_comb begin
    clr_d        = clr_q;
    act_d        = act_q;
    key_d        = key_q;
    val_d        = val_q;
    hash_d       = hash_q;
    byte_n_d     = byte_n_q;
    bit_n_d      = bit_n_q;
    quo_d        = quo_q;
    rem_d        = rem_q;
    idx_d        = idx_q;
    prev_d       = prev_q;
    i_d          = i_q;
    found_d      = found_q;
    pos_d        = pos_q;
    pos_val_d    = pos_val_q;
    pos_dist_d   = pos_dist_q;
    ck_d         = ck_q;
    cv_d         = cv_q;
    cd_d         = cd_q;
    res_status_d = cmd_i.set_status ? cmd_i.status : res_status_q;
    res_fval_d   = res_fval_q;
    count_d      = count_q;
    limit_d      = cfg_valid_i ? cfg_data_i : limit_q;
    rsp_valid_d  = rsp_valid_q && !rsp_ready_i;
    rsp_status_d = rsp_status_q;
    rsp_fval_d   = rsp_fval_q;
    rsp_count_d  = rsp_count_q;
    we           = 1'b0;
    wa           = idx_q;
    wv           = 1'b0;
    wk           = '0;
    wval         = '0;
    wd           = '0;

    unique case (cmd_i.op)
      rhht_pkg::OP_CLEAR: begin
        we    = 1'b1;
        wa    = clr_q;
        clr_d = nxt(clr_q);
      end
      rhht_pkg::OP_LOAD: begin
        act_d        = req_action_i;
        key_d        = norm_key(req_key_i);
        val_d        = req_value_i;
        hash_d       = rhht_pkg::FNV_BASIS;
        byte_n_d     = '0;
        bit_n_d      = '0;
        rem_d        = '0;
        found_d      = 1'b0;
        res_status_d = rhht_pkg::ST_NOTFOUND;
        res_fval_d   = '0;
      end
      rhht_pkg::OP_HASH: begin
        // Zero bytes only follow the end of the key after normalization
        if (hbyte != 8'd0) hash_d = prod[31:0];
        byte_n_d = byte_n_q + 3'd1;
      end
      rhht_pkg::OP_MOD: begin
        // Quotient by reciprocal multiply first, then subtract back
        if (bit_n_q == 5'd0) begin
          quo_d = HW'(mulp >> SH);
        end else begin
          rem_d = IW'(hash_q - HW'(quo_q * HW'(CAPACITY)));
        end
        bit_n_d = bit_n_q + 5'd1;
      end
      rhht_pkg::OP_FIND_INIT: begin
        idx_d = rem_q;
        i_d   = '0;
      end
      rhht_pkg::OP_FIND_CHK: begin
        if (f_hit) begin
          found_d    = 1'b1;
          pos_d      = idx_q;
          pos_val_d  = rd_val_q;
          pos_dist_d = rd_d_q;
        end else if (!f_miss) begin
          idx_d = nxt(idx_q);
          i_d   = i_q + IW'(1);
        end
      end
      rhht_pkg::OP_GET_HIT: begin
        res_status_d = rhht_pkg::ST_OK;
        res_fval_d   = pos_val_q;
      end
      rhht_pkg::OP_UPDATE: begin
        we           = 1'b1;
        wa           = pos_q;
        wv           = 1'b1;
        wk           = key_q;
        wval         = val_q;
        wd           = pos_dist_q;
        res_status_d = rhht_pkg::ST_OK;
      end
      rhht_pkg::OP_INS_INIT: begin
        idx_d = rem_q;
        i_d   = '0;
        ck_d  = key_q;
        cv_d  = val_q;
        cd_d  = '0;
      end
      rhht_pkg::OP_INS_CHK: begin
        if (!rd_v_q) begin
          we           = 1'b1;
          wv           = 1'b1;
          wk           = ck_q;
          wval         = cv_q;
          wd           = IW'(cd_q);
          count_d      = count_q + CW'(1);
          res_status_d = rhht_pkg::ST_OK;
        end else begin
          if (cd_q > {1'b0, rd_d_q}) begin
            // Swap with the richer entry and carry it on
            we   = 1'b1;
            wv   = 1'b1;
            wk   = ck_q;
            wval = cv_q;
            wd   = IW'(cd_q);
            ck_d = rd_k_q;
            cv_d = rd_val_q;
            cd_d = {1'b0, rd_d_q} + (IW+1)'(1);
          end else begin
            cd_d = cd_q + (IW+1)'(1);
          end
          idx_d = nxt(idx_q);
          i_d   = i_q + IW'(1);
          if (i_q == LAST_IDX) res_status_d = rhht_pkg::ST_NOROOM;
        end
      end
      rhht_pkg::OP_REM_INIT: begin
        we           = 1'b1;
        wa           = pos_q;
        count_d      = count_q - CW'(1);
        prev_d       = pos_q;
        idx_d        = nxt(pos_q);
        i_d          = IW'(1);
        res_status_d = rhht_pkg::ST_OK;
      end
      rhht_pkg::OP_REM_CHK: begin
        we   = 1'b1;
        wa   = prev_q;
        wv   = 1'b1;
        wk   = rd_k_q;
        wval = rd_val_q;
        wd   = rd_d_q - IW'(1);
      end
      rhht_pkg::OP_REM_CLR: begin
        we     = 1'b1;
        prev_d = idx_q;
        idx_d  = nxt(idx_q);
        i_d    = i_q + IW'(1);
      end
      rhht_pkg::OP_EMIT: begin
        rsp_valid_d  = 1'b1;
        rsp_status_d = res_status_q;
        rsp_fval_d   = res_fval_q;
        rsp_count_d  = count_q;
      end
      default: ;
    endcase
  end

  assign sts_o.clr_last   = (clr_q == LAST_IDX);
  assign sts_o.hash_last  = (byte_n_q == 3'd7);
  assign sts_o.mod_last   = (bit_n_q == 5'd1);
  assign sts_o.find_end   = f_miss || f_hit || (i_q == LAST_IDX);
  assign sts_o.found      = found_q;
  assign sts_o.act        = act_q;
  assign sts_o.over_limit = (LW'(count_q) >= LW'(limit_q));
  assign sts_o.full       = (count_q == CW'(CAPACITY));
  assign sts_o.ins_end    = !rd_v_q || (i_q == LAST_IDX);
  assign sts_o.rem_stop   = !rd_v_q || (rd_d_q == '0);
  assign sts_o.rem_last   = (i_q == LAST_IDX);
  assign sts_o.out_busy   = rsp_valid_q && !rsp_ready_i;

  assign rsp_valid_o       = rsp_valid_q;
  assign rsp_status_o      = rsp_status_q;
  assign rsp_found_value_o = rsp_fval_q;
  assign rsp_entry_count_o = rsp_count_q;

endmodule

// ===== sv/robin_hood_hash_table.sv =====
// Robin Hood hash table with backward-shift deletion: top level.
// Depends on rhht_pkg, the three channel interfaces, rhht_ctrl and rhht_dp.
//
// Usage: send one request word (action get/put/remove, key, value) on req_i;
// one response word (status, found_value, entry_count) comes back on rsp_o
// for each request, in order. cfg_i writes load_limit and is always ready;
// write it only while no request is in flight.
// Each request passes a load step, the FNV-1a hash of its key one byte at a
// time through the 32x32 multiplier, a modulo step (reciprocal multiply, then
// subtract back), a read and check of each probed slot through the slot memory
// (plus a rewrite of each shifted slot on remove), then a dispatch step and an
// emit step; the probe walk can span up to CAPACITY slots.
// One request is worked on at a time; req_i is ready again as soon as the
// response sits in the output register, even while the receiver stalls.
// A stalled response holds the controller in its final step until taken.
// Reset: load_limit returns to 24, the count to zero, and a clearing pass
// invalidates every slot; req_i stays low meanwhile.
module robin_hood_hash_table #(
  parameter int unsigned CAPACITY  = 32,
  parameter int unsigned KEY_BYTES = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rhht_req_if.sink    req_i,
  rhht_rsp_if.source  rsp_o,
  rhht_cfg_if.sink    cfg_i
);

  rhht_pkg::dp_cmd_t cmd;
  rhht_pkg::dp_sts_t sts;

  // Config register takes a word on any cycle
  assign cfg_i.ready = 1'b1;

  rhht_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  rhht_dp #(
    .CAPACITY  (CAPACITY),
    .KEY_BYTES (KEY_BYTES)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .req_action_i      (req_i.action),
    .req_key_i         (req_i.key),
    .req_value_i       (req_i.value),
    .cfg_valid_i       (cfg_i.valid),
    .cfg_data_i        (cfg_i.data),
    .rsp_ready_i       (rsp_o.ready),
    .rsp_valid_o       (rsp_o.valid),
    .rsp_status_o      (rsp_o.status),
    .rsp_found_value_o (rsp_o.found_value),
    .rsp_entry_count_o (rsp_o.entry_count)
  );

endmodule

// ===== dv/robin_hood_hash_table_test.sv =====
// Randomized and directed test of the Robin Hood hash table.
// Depends on rhht_pkg, the three channel interfaces and robin_hood_hash_table.
module robin_hood_hash_table_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SLOTS = 32;
  localparam int unsigned IDLE_LIMIT = 20000;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  // Table predictor plus the queue of expected response words.
  class rhht_scoreboard;
    bit              occ [SLOTS];
    logic [63:0]     skey [SLOTS];
    logic [31:0]     sval [SLOTS];
    int unsigned     sdist [SLOTS];
    int unsigned     count;
    int unsigned     limit;
    logic [1:0]      exp_status [$];
    logic [31:0]     exp_value [$];
    logic [5:0]      exp_count [$];
    int unsigned     errors;

    function new();
      count = 0;
      limit = 24;
      errors = 0;
      foreach (occ[i]) occ[i] = 0;
    endfunction

    function logic [63:0] trim_key(logic [63:0] k);
      logic [63:0] r;
      r = '0;
      for (int b = 0; b < 8; b++) begin
        if (k[8*b +: 8] == 8'd0) break;
        r[8*b +: 8] = k[8*b +: 8];
      end
      return r;
    endfunction

    function int unsigned home_of(logic [63:0] k);
      logic [31:0] h;
      h = rhht_pkg::FNV_BASIS;
      for (int b = 0; b < 8; b++) begin
        if (k[8*b +: 8] == 8'd0) break;
        h = (h ^ {24'd0, k[8*b +: 8]}) * rhht_pkg::FNV_PRIME;
      end
      return h % SLOTS;
    endfunction

    function int locate(logic [63:0] k, int unsigned home);
      int unsigned idx;
      for (int unsigned i = 0; i < SLOTS; i++) begin
        idx = (home + i) % SLOTS;
        if (!occ[idx] || sdist[idx] < i) return -1;
        if (skey[idx] == k) return idx;
      end
      return -1;
    endfunction

    // Apply one accepted request word and queue its response.
    function void note_request(logic [1:0] act, logic [63:0] raw_key, logic [31:0] v);
      logic [63:0] k, ck, tk;
      logic [31:0] cv, tv, fv;
      logic [1:0]  st;
      int unsigned home, cd, td, idx, cur, prv;
      int pos;
      k = trim_key(raw_key);
      home = home_of(k);
      pos = locate(k, home);
      st = rhht_pkg::ST_NOTFOUND;
      fv = '0;
      if (act == rhht_pkg::ACT_GET) begin
        if (pos >= 0) begin
          st = rhht_pkg::ST_OK;
          fv = sval[pos];
        end
      end else if (act == rhht_pkg::ACT_PUT) begin
        if (count >= limit) st = rhht_pkg::ST_LIMIT;
        else if (pos >= 0) begin
          sval[pos] = v;
          st = rhht_pkg::ST_OK;
        end else if (count >= SLOTS) st = rhht_pkg::ST_NOROOM;
        else begin
          ck = k; cv = v; cd = 0;
          for (int unsigned i = 0; i < SLOTS; i++) begin
            idx = (home + i) % SLOTS;
            if (!occ[idx]) begin
              occ[idx] = 1; skey[idx] = ck; sval[idx] = cv; sdist[idx] = cd;
              count++;
              break;
            end
            if (cd > sdist[idx]) begin
              tk = skey[idx]; tv = sval[idx]; td = sdist[idx];
              skey[idx] = ck; sval[idx] = cv; sdist[idx] = cd;
              ck = tk; cv = tv; cd = td;
            end
            cd++;
          end
          st = rhht_pkg::ST_OK;
        end
      end else if (act == rhht_pkg::ACT_REMOVE) begin
        if (pos >= 0) begin
          occ[pos] = 0;
          count--;
          for (int unsigned i = 1; i < SLOTS; i++) begin
            cur = (pos + i) % SLOTS;
            prv = (pos + i - 1) % SLOTS;
            if (!occ[cur] || sdist[cur] == 0) break;
            occ[prv] = 1; skey[prv] = skey[cur]; sval[prv] = sval[cur];
            sdist[prv] = sdist[cur] - 1;
            occ[cur] = 0;
          end
          st = rhht_pkg::ST_OK;
        end
      end
      exp_status.push_back(st);
      exp_value.push_back(fv);
      exp_count.push_back(count[5:0]);
    endfunction

    function void check_response(logic [1:0] st, logic [31:0] fv, logic [5:0] cnt);
      if (exp_status.size() == 0) begin
        $display("%0t: unexpected response status=%0d value=%0d count=%0d",
                 $realtime, st, $signed(fv), cnt);
        errors++;
        return;
      end
      if (st !== exp_status[0]) begin
        $display("%0t: status expected %0d actual %0d", $realtime, exp_status[0], st);
        errors++;
      end
      if (fv !== exp_value[0]) begin
        $display("%0t: found_value expected %0d actual %0d", $realtime,
                 $signed(exp_value[0]), $signed(fv));
        errors++;
      end
      if (cnt !== exp_count[0]) begin
        $display("%0t: entry_count expected %0d actual %0d", $realtime, exp_count[0], cnt);
        errors++;
      end
      void'(exp_status.pop_front());
      void'(exp_value.pop_front());
      void'(exp_count.pop_front());
    endfunction

    function int unsigned pending();
      return exp_status.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #1 clk_i = ~clk_i;

  rhht_req_if req_if ();
  rhht_rsp_if #(.CNT_W(6)) rsp_if ();
  rhht_cfg_if cfg_if ();

  robin_hood_hash_table DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if.sink),
    .rsp_o  (rsp_if.source),
    .cfg_i  (cfg_if.sink)
  );

  rhht_scoreboard table_sb = new();

  bit          quiet_tail = 0;   // no idling in the last part
  bit          hold_rsp = 0;     // long receiver stall requested
  int unsigned idle_cycles = 0;
  logic [63:0] key_pool [16];

  // Sample at the rising edge: note accepted requests and check responses.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req_if.valid && req_if.ready)
        table_sb.note_request(req_if.action, req_if.key, req_if.value);
      if (rsp_if.valid && rsp_if.ready)
        table_sb.check_response(rsp_if.status, rsp_if.found_value, rsp_if.entry_count);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (cfg_if.valid && cfg_if.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
    end
  end

  // Watchdog: stop when nothing has moved for too long.
  always @(posedge clk_i) begin
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Receiver: random stall bursts, or a long hold-off when asked.
  initial begin
    int unsigned gap;
    rsp_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_rsp) begin
        rsp_if.ready <= 1'b0;
        for (int i = 0; i < 400; i++) @(negedge clk_i);
        hold_rsp = 0;
      end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 3);
        rsp_if.ready <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // Offer one request word and hold it until taken; valid stays up for the
  // next word unless an idle gap or a drain drops it.
  task automatic send_word(logic [1:0] act, logic [63:0] k, logic [31:0] v);
    if (!quiet_tail && $urandom_range(0, 4) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.action <= act;
    req_if.key <= k;
    req_if.value <= v;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Drop valid, wait out every expected response, then the block's last cycles.
  task automatic drain();
    req_if.valid <= 1'b0;
    while (table_sb.pending() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_limit(logic [5:0] lim);
    drain();
    cfg_if.valid <= 1'b1;
    cfg_if.data <= lim;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    table_sb.limit = lim;
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  function automatic logic [63:0] rand_key();
    logic [63:0] k;
    int unsigned n;
    k = {$urandom, $urandom};
    n = $urandom_range(0, 8);
    for (int b = 0; b < 8; b++)
      if (b >= n) k[8*b +: 8] = 8'd0;
      else if (k[8*b +: 8] == 8'd0) k[8*b +: 8] = 8'h41;
    return k;
  endfunction

  // Mostly keys from a small pool so gets and removes hit; some raw noise.
  function automatic logic [63:0] pick_key();
    if ($urandom_range(0, 9) == 0) return {$urandom, $urandom};
    return key_pool[$urandom_range(0, 15)];
  endfunction

  task automatic random_phase(int unsigned n, int unsigned put_weight);
    logic [1:0] act;
    int unsigned r;
    for (int unsigned i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < put_weight) act = rhht_pkg::ACT_PUT;
      else if (r < put_weight + 30) act = rhht_pkg::ACT_GET;
      else if (r < 97) act = rhht_pkg::ACT_REMOVE;
      else act = ACT_UNUSED;
      send_word(act, pick_key(), $urandom);
    end
  endtask

  initial begin
    req_if.valid = 1'b0;
    req_if.action = rhht_pkg::ACT_GET;
    req_if.key = '0;
    req_if.value = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    foreach (key_pool[i]) key_pool[i] = rand_key();
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: empty key, padding after a zero byte, all-ones key, value
    // extremes, unused action, update, remove miss and hit.
    send_word(rhht_pkg::ACT_GET, 64'd0, 32'd0);
    send_word(rhht_pkg::ACT_PUT, 64'd0, 32'h7fffffff);
    send_word(rhht_pkg::ACT_GET, 64'hff00_0000_0000_0000, 32'd0);
    send_word(rhht_pkg::ACT_PUT, 64'hffff_ffff_ffff_ffff, 32'h80000000);
    send_word(rhht_pkg::ACT_GET, 64'hffff_ffff_ffff_ffff, 32'd5);
    send_word(rhht_pkg::ACT_PUT, 64'h0000_0000_0000_4142, 32'd1);
    send_word(rhht_pkg::ACT_PUT, 64'h5500_0000_0000_4142, 32'hffffffff);
    send_word(rhht_pkg::ACT_GET, 64'h0000_0000_0000_4142, 32'd0);
    send_word(ACT_UNUSED, 64'h0000_0000_0000_4142, 32'd0);
    send_word(rhht_pkg::ACT_REMOVE, 64'h0000_0000_0000_0077, 32'd0);
    send_word(rhht_pkg::ACT_REMOVE, 64'h0000_0000_0000_4142, 32'd0);
    send_word(rhht_pkg::ACT_GET, 64'h0000_0000_0000_4142, 32'd0);
    send_word(rhht_pkg::ACT_REMOVE, 64'd0, 32'd0);

    // Limit of zero: every put refused, update included.
    write_limit(6'd0);
    send_word(rhht_pkg::ACT_PUT, 64'hffff_ffff_ffff_ffff, 32'd9);
    send_word(rhht_pkg::ACT_PUT, 64'h0000_0000_0000_0031, 32'd9);

    // Limit above capacity: fill all slots, then hit the no-room case.
    write_limit(6'd63);
    for (int i = 0; i < 36; i++) send_word(rhht_pkg::ACT_PUT, rand_key() | 64'h1, $urandom);
    random_phase(60, 40);

    // Long receiver stall while requests keep coming.
    write_limit(6'd32);
    hold_rsp = 1;
    random_phase(60, 40);

    // Sender pauses until every response is back.
    drain();
    write_limit(6'd24);
    random_phase(200, 45);
    write_limit(6'd5);
    random_phase(100, 50);
    write_limit(6'd40);
    for (int i = 0; i < 40; i++) send_word(rhht_pkg::ACT_REMOVE, key_pool[i % 16], 32'd0);
    random_phase(200, 45);
    write_limit(6'd16);
    quiet_tail = 1;
    random_phase(150, 40);

    drain();
    if (table_sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
sv/rhht_pkg.sv
sv/rhht_req_if.sv
sv/rhht_rsp_if.sv
sv/rhht_cfg_if.sv
sv/rhht_ctrl.sv
sv/rhht_dp.sv
sv/robin_hood_hash_table.sv
dv/robin_hood_hash_table_test.sv
